### rtl/core/exu_pkg.sv
// ----------------------------------------------------------------------------
// exu_pkg
// Shared types and constants of the execute unit: instruction codes, error
// codes, the decoded micro-op and the result record.
// ----------------------------------------------------------------------------
package exu_pkg;

    localparam int MEM_WORDS_DEF = 1024;
    localparam int OUT_DEPTH     = 4;
    localparam int OUT_CNT_W     = $clog2(OUT_DEPTH + 1);
    localparam int OUT_PTR_W     = $clog2(OUT_DEPTH);
    localparam int UQ_DEPTH      = 2;
    localparam int UQ_CNT_W      = $clog2(UQ_DEPTH + 1);
    localparam int UQ_PTR_W      = $clog2(UQ_DEPTH);

    // request types
    localparam logic [1:0] REQ_EXEC    = 2'd0;
    localparam logic [1:0] REQ_PRELOAD = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    // primary opcodes
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2B;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_J     = 6'h02;

    // r-type function codes
    localparam logic [5:0] FN_ADD = 6'h20;
    localparam logic [5:0] FN_SUB = 6'h22;
    localparam logic [5:0] FN_AND = 6'h24;
    localparam logic [5:0] FN_OR  = 6'h25;
    localparam logic [5:0] FN_SLT = 6'h2A;

    // error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_OPCODE = 2'd1;
    localparam logic [1:0] ERR_FUNCT  = 2'd2;
    localparam logic [1:0] ERR_ADDR   = 2'd3;

    localparam logic [31:0] PC_STEP        = 32'd4;
    localparam logic [31:0] PC_REGION_MASK = 32'hF000_0000;

    typedef enum logic [3:0] {
        K_NOP,
        K_PRELOAD,
        K_READ,
        K_ALU,
        K_ADDI,
        K_LW,
        K_SW,
        K_BEQ,
        K_BNE,
        K_J,
        K_ERR
    } t_kind;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_AND,
        ALU_OR,
        ALU_SLT
    } t_alu;

    typedef struct packed {
        t_kind       kind;
        t_alu        alu;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic [4:0]  wd;
        logic [25:0] imm;
        logic [31:0] pc;
        logic [31:0] wval;
        logic [1:0]  err;
    } t_uop;

    typedef struct packed {
        logic [31:0] res;
        logic [31:0] npc;
        logic        tk;
        logic [1:0]  err;
    } t_result;

    typedef struct packed {
        logic                 clr_busy;
        logic [1:0]           inflight;
        logic [OUT_CNT_W-1:0] out_cnt;
    } t_back_stat;

endpackage

### rtl/core/exu_front.sv
// ----------------------------------------------------------------------------
// exu_front
// Request intake: takes the push handshake and classifies each request into
// a micro-op with its operand and destination register numbers.
// ----------------------------------------------------------------------------
module exu_front (
    input  logic               i_push,
    input  logic               i_busy,
    output logic               o_full,
    output logic               o_uop_push,
    input  logic [1:0]         i_req_type,
    input  logic [5:0]         i_opcode,
    input  logic [5:0]         i_func_code,
    input  logic [4:0]         i_src_reg_a,
    input  logic [4:0]         i_src_reg_b,
    input  logic [4:0]         i_dest_reg,
    input  logic [25:0]        i_imm_value,
    input  logic [31:0]        i_pc_value,
    input  logic [4:0]         i_reg_index,
    input  logic [31:0]        i_write_value,
    output exu_pkg::t_uop      o_uop
);

    assign o_full     = i_busy;
    assign o_uop_push = i_push && !i_busy;

    always_comb begin
        o_uop      = '0;
        o_uop.kind = exu_pkg::K_NOP;
        o_uop.alu  = exu_pkg::ALU_ADD;
        o_uop.imm  = i_imm_value;
        o_uop.pc   = i_pc_value;
        o_uop.wval = i_write_value;
        o_uop.err  = exu_pkg::ERR_NONE;
        case (i_req_type)
            exu_pkg::REQ_PRELOAD: begin
                o_uop.kind = exu_pkg::K_PRELOAD;
                o_uop.wd   = i_reg_index;
            end
            exu_pkg::REQ_READ: begin
                o_uop.kind = exu_pkg::K_READ;
                o_uop.ra   = i_reg_index;
            end
            exu_pkg::REQ_EXEC: begin
                o_uop.ra = i_src_reg_a;
                o_uop.rb = i_src_reg_b;
                o_uop.wd = i_src_reg_b;
                case (i_opcode)
                    exu_pkg::OP_RTYPE: begin
                        o_uop.kind = exu_pkg::K_ALU;
                        o_uop.wd   = i_dest_reg;
                        case (i_func_code)
                            exu_pkg::FN_ADD: o_uop.alu = exu_pkg::ALU_ADD;
                            exu_pkg::FN_SUB: o_uop.alu = exu_pkg::ALU_SUB;
                            exu_pkg::FN_AND: o_uop.alu = exu_pkg::ALU_AND;
                            exu_pkg::FN_OR:  o_uop.alu = exu_pkg::ALU_OR;
                            exu_pkg::FN_SLT: o_uop.alu = exu_pkg::ALU_SLT;
                            default: begin
                                o_uop.kind = exu_pkg::K_ERR;
                                o_uop.err  = exu_pkg::ERR_FUNCT;
                            end
                        endcase
                    end
                    exu_pkg::OP_ADDI: o_uop.kind = exu_pkg::K_ADDI;
                    exu_pkg::OP_LW:   o_uop.kind = exu_pkg::K_LW;
                    exu_pkg::OP_SW:   o_uop.kind = exu_pkg::K_SW;
                    exu_pkg::OP_BEQ:  o_uop.kind = exu_pkg::K_BEQ;
                    exu_pkg::OP_BNE:  o_uop.kind = exu_pkg::K_BNE;
                    exu_pkg::OP_J:    o_uop.kind = exu_pkg::K_J;
                    default: begin
                        o_uop.kind = exu_pkg::K_ERR;
                        o_uop.err  = exu_pkg::ERR_OPCODE;
                    end
                endcase
            end
            default: o_uop.kind = exu_pkg::K_NOP;
        endcase
    end

endmodule

### rtl/core/exu_uop_queue.sv
// ----------------------------------------------------------------------------
// exu_uop_queue
// Two-entry queue of decoded micro-ops between the front and the back end.
// ----------------------------------------------------------------------------
module exu_uop_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  exu_pkg::t_uop                 i_uop,
    input  logic                          i_pop,
    output exu_pkg::t_uop                 o_uop,
    output logic                          o_empty,
    output logic                          o_full,
    output logic [exu_pkg::UQ_CNT_W-1:0]  o_cnt
);

    exu_pkg::t_uop                 r_buf [exu_pkg::UQ_DEPTH];
    logic [exu_pkg::UQ_PTR_W-1:0]  r_wp;
    logic [exu_pkg::UQ_PTR_W-1:0]  r_rp;
    logic [exu_pkg::UQ_CNT_W-1:0]  r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == exu_pkg::UQ_CNT_W'(exu_pkg::UQ_DEPTH));
    assign o_cnt   = r_cnt;
    assign o_uop   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_uop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/core/exu_back.sv
// ----------------------------------------------------------------------------
// exu_back
// Execution back end: register read, execute with data memory access, and
// writeback into a small result queue. Also runs the memory clearing pass.
// ----------------------------------------------------------------------------
module exu_back #(
    parameter int MEM_WORDS = exu_pkg::MEM_WORDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  exu_pkg::t_uop       i_uop,
    input  logic                i_uop_vld,
    output logic                o_uop_pop,
    input  logic                i_res_pop,
    output exu_pkg::t_result    o_res,
    output logic                o_res_empty,
    output exu_pkg::t_back_stat o_stat
);

    localparam int AW = $clog2(MEM_WORDS);

    // memory clearing pass
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // register file with valid bits
    logic [31:0] r_rf [32];
    logic [31:0] r_rf_vld;
    logic [31:0] r_rd_a;
    logic [31:0] r_rd_b;

    // data memory
    logic [31:0] r_dmem [MEM_WORDS];
    logic [31:0] r_mem_rdata;

    // execute stage
    logic          r_e2_vld;
    exu_pkg::t_uop r_e2_uop;

    // writeback stage
    logic        r_e3_vld;
    logic        r_e3_load;
    logic        r_e3_we;
    logic [4:0]  r_e3_dest;
    logic [31:0] r_e3_wdata;
    logic [31:0] r_e3_res;
    logic [31:0] r_e3_npc;
    logic        r_e3_tk;
    logic [1:0]  r_e3_err;

    logic        n_e3_load;
    logic        n_e3_we;
    logic [31:0] n_e3_wdata;
    logic [31:0] n_e3_res;
    logic [31:0] n_e3_npc;
    logic        n_e3_tk;
    logic [1:0]  n_e3_err;

    // result queue
    exu_pkg::t_result                r_oq [exu_pkg::OUT_DEPTH];
    logic [exu_pkg::OUT_PTR_W-1:0]   r_oq_wp;
    logic [exu_pkg::OUT_PTR_W-1:0]   r_oq_rp;
    logic [exu_pkg::OUT_CNT_W-1:0]   r_oq_cnt;

    logic        w_wb_we;
    logic [31:0] w_wb_data;
    logic [31:0] w_out_res;
    logic [1:0]  w_inflight;
    logic [exu_pkg::OUT_CNT_W:0] w_credit;
    logic        w_issue;
    logic        w_oq_pop;
    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [31:0] w_simm;
    logic [31:0] w_sum;
    logic        w_addr_ok;
    logic [AW-1:0] w_mem_idx;
    logic        w_sw_we;

    assign w_wb_we   = r_e3_vld && r_e3_we;
    assign w_wb_data = r_e3_load ? r_mem_rdata : r_e3_wdata;
    assign w_out_res = r_e3_load ? r_mem_rdata : r_e3_res;

    // issue only when the result queue has room for everything in flight
    assign w_inflight = 2'(r_e2_vld) + 2'(r_e3_vld);
    assign w_credit   = (exu_pkg::OUT_CNT_W + 1)'(r_oq_cnt)
                      + (exu_pkg::OUT_CNT_W + 1)'(w_inflight);
    assign w_issue    = i_uop_vld && !r_clr_busy
                      && (w_credit < (exu_pkg::OUT_CNT_W + 1)'(exu_pkg::OUT_DEPTH));
    assign o_uop_pop  = w_issue;

    assign o_stat.clr_busy = r_clr_busy;
    assign o_stat.inflight = w_inflight;
    assign o_stat.out_cnt  = r_oq_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(MEM_WORDS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // register read, bypassing the write that lands on the same edge
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            if (w_wb_we && r_e3_dest == i_uop.ra) begin
                r_rd_a <= w_wb_data;
            end else begin
                r_rd_a <= r_rf_vld[i_uop.ra] ? r_rf[i_uop.ra] : '0;
            end
            if (w_wb_we && r_e3_dest == i_uop.rb) begin
                r_rd_b <= w_wb_data;
            end else begin
                r_rd_b <= r_rf_vld[i_uop.rb] ? r_rf[i_uop.rb] : '0;
            end
            r_e2_uop <= i_uop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wb_we) begin
            r_rf[r_e3_dest] <= w_wb_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (w_wb_we) begin
            r_rf_vld[r_e3_dest] <= 1'b1;
        end
    end

    // forward from the instruction now in writeback
    assign w_a = (w_wb_we && r_e3_dest == r_e2_uop.ra) ? w_wb_data : r_rd_a;
    assign w_b = (w_wb_we && r_e3_dest == r_e2_uop.rb) ? w_wb_data : r_rd_b;

    assign w_simm    = {{16{r_e2_uop.imm[15]}}, r_e2_uop.imm[15:0]};
    assign w_sum     = w_a + w_simm;
    assign w_addr_ok = (w_sum < 32'(MEM_WORDS));
    assign w_mem_idx = w_sum[AW-1:0];
    assign w_sw_we   = r_e2_vld && (r_e2_uop.kind == exu_pkg::K_SW) && w_addr_ok;

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_dmem[r_clr_addr] <= '0;
        end else if (w_sw_we) begin
            r_dmem[w_mem_idx] <= w_b;
        end
        r_mem_rdata <= r_dmem[w_mem_idx];
    end

    always_comb begin
        n_e3_load  = 1'b0;
        n_e3_we    = 1'b0;
        n_e3_wdata = '0;
        n_e3_res   = '0;
        n_e3_npc   = r_e2_uop.pc;
        n_e3_tk    = 1'b0;
        n_e3_err   = exu_pkg::ERR_NONE;
        case (r_e2_uop.kind)
            exu_pkg::K_PRELOAD: begin
                n_e3_we    = 1'b1;
                n_e3_wdata = r_e2_uop.wval;
                n_e3_npc   = '0;
            end
            exu_pkg::K_READ: begin
                n_e3_res = w_a;
                n_e3_npc = '0;
            end
            exu_pkg::K_ALU: begin
                n_e3_we = 1'b1;
                case (r_e2_uop.alu)
                    exu_pkg::ALU_ADD: n_e3_res = w_a + w_b;
                    exu_pkg::ALU_SUB: n_e3_res = w_a - w_b;
                    exu_pkg::ALU_AND: n_e3_res = w_a & w_b;
                    exu_pkg::ALU_OR:  n_e3_res = w_a | w_b;
                    exu_pkg::ALU_SLT: n_e3_res = {31'd0, $signed(w_a) < $signed(w_b)};
                    default:          n_e3_res = '0;
                endcase
                n_e3_wdata = n_e3_res;
            end
            exu_pkg::K_ADDI: begin
                n_e3_we    = 1'b1;
                n_e3_res   = w_sum;
                n_e3_wdata = w_sum;
            end
            exu_pkg::K_LW: begin
                if (w_addr_ok) begin
                    n_e3_load = 1'b1;
                    n_e3_we   = 1'b1;
                end else begin
                    n_e3_err = exu_pkg::ERR_ADDR;
                end
            end
            exu_pkg::K_SW: begin
                if (!w_addr_ok) begin
                    n_e3_err = exu_pkg::ERR_ADDR;
                end
            end
            exu_pkg::K_BEQ, exu_pkg::K_BNE: begin
                if ((r_e2_uop.kind == exu_pkg::K_BEQ) == (w_a == w_b)) begin
                    n_e3_tk  = 1'b1;
                    n_e3_npc = r_e2_uop.pc + {w_simm[29:0], 2'b00} - exu_pkg::PC_STEP;
                end
            end
            exu_pkg::K_J: begin
                n_e3_tk  = 1'b1;
                n_e3_npc = ((r_e2_uop.pc + exu_pkg::PC_STEP) & exu_pkg::PC_REGION_MASK)
                         | {4'd0, r_e2_uop.imm, 2'b00};
            end
            exu_pkg::K_ERR: n_e3_err = r_e2_uop.err;
            default: n_e3_npc = '0;
        endcase
        // register zero is never written
        if (r_e2_uop.wd == '0) begin
            n_e3_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e3_load  <= n_e3_load;
        r_e3_we    <= n_e3_we;
        r_e3_dest  <= r_e2_uop.wd;
        r_e3_wdata <= n_e3_wdata;
        r_e3_res   <= n_e3_res;
        r_e3_npc   <= n_e3_npc;
        r_e3_tk    <= n_e3_tk;
        r_e3_err   <= n_e3_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_vld <= 1'b0;
            r_e3_vld <= 1'b0;
        end else begin
            r_e2_vld <= w_issue;
            r_e3_vld <= r_e2_vld;
        end
    end

    // result queue
    assign w_oq_pop    = i_res_pop && (r_oq_cnt != '0);
    assign o_res_empty = (r_oq_cnt == '0);
    assign o_res       = r_oq[r_oq_rp];

    always_ff @(posedge i_clk) begin
        if (r_e3_vld) begin
            r_oq[r_oq_wp] <= '{res: w_out_res, npc: r_e3_npc, tk: r_e3_tk, err: r_e3_err};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (r_e3_vld) begin
                r_oq_wp <= r_oq_wp + 1'b1;
            end
            if (w_oq_pop) begin
                r_oq_rp <= r_oq_rp + 1'b1;
            end
            if (r_e3_vld && !w_oq_pop) begin
                r_oq_cnt <= r_oq_cnt + 1'b1;
            end else if (!r_e3_vld && w_oq_pop) begin
                r_oq_cnt <= r_oq_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/core/mips_subset_execute_unit.sv
// ----------------------------------------------------------------------------
// mips_subset_execute_unit
// Execute stage for a small MIPS-style subset with register file and data
// memory, queue interfaces on both sides.
// ----------------------------------------------------------------------------
// Takes one request per cycle while full is low (execute, register preload or
// register read) and returns one result per request in order. A request
// passes the decode queue, the register read, execute and memory access,
// then the result queue. Loads feed their data straight into the next
// instruction, so no sequence of instructions slows the flow; the only limit
// is the four-entry result queue, which stops intake once its free room is
// taken by results in flight. After reset the data memory is zeroed one word
// per cycle, so full stays high until every word is cleared, before the first
// request is taken.
module mips_subset_execute_unit #(
    parameter int MEM_WORDS = exu_pkg::MEM_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_req_type,
    input  logic [5:0]  i_opcode,
    input  logic [5:0]  i_func_code,
    input  logic [4:0]  i_src_reg_a,
    input  logic [4:0]  i_src_reg_b,
    input  logic [4:0]  i_dest_reg,
    input  logic [25:0] i_imm_value,
    input  logic [31:0] i_pc_value,
    input  logic [4:0]  i_reg_index,
    input  logic [31:0] i_write_value,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_result_value,
    output logic [31:0] o_next_pc,
    output logic        o_taken,
    output logic [1:0]  o_error_code
);

    exu_pkg::t_uop                  w_dec_uop;
    exu_pkg::t_uop                  w_head_uop;
    logic                           w_uop_push;
    logic                           w_uop_pop;
    logic                           w_q_empty;
    logic                           w_q_full;
    logic [exu_pkg::UQ_CNT_W-1:0]   w_q_cnt;
    exu_pkg::t_result               w_res;
    exu_pkg::t_back_stat            w_stat;

    exu_front u_front (
        .i_push        (push),
        .i_busy        (w_q_full || w_stat.clr_busy),
        .o_full        (full),
        .o_uop_push    (w_uop_push),
        .i_req_type    (i_req_type),
        .i_opcode      (i_opcode),
        .i_func_code   (i_func_code),
        .i_src_reg_a   (i_src_reg_a),
        .i_src_reg_b   (i_src_reg_b),
        .i_dest_reg    (i_dest_reg),
        .i_imm_value   (i_imm_value),
        .i_pc_value    (i_pc_value),
        .i_reg_index   (i_reg_index),
        .i_write_value (i_write_value),
        .o_uop         (w_dec_uop)
    );

    exu_uop_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_uop_push),
        .i_uop   (w_dec_uop),
        .i_pop   (w_uop_pop),
        .o_uop   (w_head_uop),
        .o_empty (w_q_empty),
        .o_full  (w_q_full),
        .o_cnt   (w_q_cnt)
    );

    exu_back #(
        .MEM_WORDS (MEM_WORDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uop       (w_head_uop),
        .i_uop_vld   (!w_q_empty),
        .o_uop_pop   (w_uop_pop),
        .i_res_pop   (pop),
        .o_res       (w_res),
        .o_res_empty (empty),
        .o_stat      (w_stat)
    );

    assign o_result_value = w_res.res;
    assign o_next_pc      = w_res.npc;
    assign o_taken        = w_res.tk;
    assign o_error_code   = w_res.err;

    // results queued plus results in flight never exceed the result queue
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((exu_pkg::OUT_CNT_W + 1)'(w_stat.out_cnt)
            + (exu_pkg::OUT_CNT_W + 1)'(w_stat.inflight))
            <= (exu_pkg::OUT_CNT_W + 1)'(exu_pkg::OUT_DEPTH))
        else $error("result credit overrun");

    // nothing is queued or executing while memory is being cleared
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.clr_busy |-> (empty && w_q_cnt == '0 && w_stat.inflight == '0))
        else $error("activity during memory clear");

    // an issued micro-op reaches the result side
    a_issue_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_uop_pop |=> ##1 (w_stat.out_cnt != '0 || $past(w_stat.inflight) != '0))
        else $error("issued instruction lost");

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for mips_subset_execute_unit. Requests are sent as
// bursts through the push/full side. A behavioral copy of the register file
// and data store predicts every result, and each popped result is compared
// field by field in order. Directed cases cover the corners of every
// instruction. A long random program with back-to-back dependencies follows,
// mixed with preloads, reads and malformed instructions.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          MEM_WORDS    = exu_pkg::MEM_WORDS_DEF;
    localparam int          RANDOM_ITEMS = 750;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 10;
    localparam logic [1:0]  REQ_UNUSED   = 2'd3;
    localparam logic [5:0]  OP_BAD       = 6'h3F;
    localparam logic [5:0]  FN_BAD       = 6'h3F;

    typedef enum int {POP_ALWAYS, POP_RANDOM, POP_SPARSE, POP_LONG_STALL} t_pop_mode;

    typedef struct {
        logic [1:0]  req_type;
        logic [5:0]  opcode;
        logic [5:0]  func_code;
        logic [4:0]  src_a;
        logic [4:0]  src_b;
        logic [4:0]  dst;
        logic [25:0] imm;
        logic [31:0] pc;
        logic [4:0]  reg_index;
        logic [31:0] write_value;
    } t_exec_req;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        push          = 1'b0;
    logic        pop           = 1'b0;
    logic [1:0]  i_req_type    = '0;
    logic [5:0]  i_opcode      = '0;
    logic [5:0]  i_func_code   = '0;
    logic [4:0]  i_src_reg_a   = '0;
    logic [4:0]  i_src_reg_b   = '0;
    logic [4:0]  i_dest_reg    = '0;
    logic [25:0] i_imm_value   = '0;
    logic [31:0] i_pc_value    = '0;
    logic [4:0]  i_reg_index   = '0;
    logic [31:0] i_write_value = '0;
    logic        full;
    logic        empty;
    logic [31:0] o_result_value;
    logic [31:0] o_next_pc;
    logic        o_taken;
    logic [1:0]  o_error_code;

    // predicted architectural state
    logic [31:0] shadow_regs [32];
    logic [31:0] shadow_mem  [MEM_WORDS];

    exu_pkg::t_result pending_results [$];
    int unsigned      error_count = 0;
    int unsigned      cycle_count = 0;
    int unsigned      burst_left  = 0;
    int unsigned      stall_left  = 0;
    t_pop_mode        stall_mode  = POP_ALWAYS;

    mips_subset_execute_unit #(.MEM_WORDS(MEM_WORDS)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_req_type     (i_req_type),
        .i_opcode       (i_opcode),
        .i_func_code    (i_func_code),
        .i_src_reg_a    (i_src_reg_a),
        .i_src_reg_b    (i_src_reg_b),
        .i_dest_reg     (i_dest_reg),
        .i_imm_value    (i_imm_value),
        .i_pc_value     (i_pc_value),
        .i_reg_index    (i_reg_index),
        .i_write_value  (i_write_value),
        .empty          (empty),
        .pop            (pop),
        .o_result_value (o_result_value),
        .o_next_pc      (o_next_pc),
        .o_taken        (o_taken),
        .o_error_code   (o_error_code)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[mips_subset_execute_unit] ERROR");
            $finish;
        end
    end

    // executes one request on the shadow state and returns its outcome
    function automatic exu_pkg::t_result execute_shadow(input t_exec_req r);
        exu_pkg::t_result o;
        logic [31:0]      a;
        logic [31:0]      b;
        logic [31:0]      simm;
        logic [31:0]      addr;
        o = '0;
        case (r.req_type)
            exu_pkg::REQ_PRELOAD: begin
                if (r.reg_index != 5'd0) shadow_regs[r.reg_index] = r.write_value;
            end
            exu_pkg::REQ_READ: begin
                o.res = shadow_regs[r.reg_index];
            end
            exu_pkg::REQ_EXEC: begin
                a     = shadow_regs[r.src_a];
                b     = shadow_regs[r.src_b];
                simm  = {{16{r.imm[15]}}, r.imm[15:0]};
                addr  = a + simm;
                o.npc = r.pc;
                case (r.opcode)
                    exu_pkg::OP_RTYPE: begin
                        case (r.func_code)
                            exu_pkg::FN_ADD: o.res = a + b;
                            exu_pkg::FN_SUB: o.res = a - b;
                            exu_pkg::FN_AND: o.res = a & b;
                            exu_pkg::FN_OR:  o.res = a | b;
                            exu_pkg::FN_SLT:
                                o.res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                            default: o.err = exu_pkg::ERR_FUNCT;
                        endcase
                        if (o.err == exu_pkg::ERR_NONE && r.dst != 5'd0)
                            shadow_regs[r.dst] = o.res;
                    end
                    exu_pkg::OP_ADDI: begin
                        o.res = a + simm;
                        if (r.src_b != 5'd0) shadow_regs[r.src_b] = o.res;
                    end
                    exu_pkg::OP_LW: begin
                        if (addr < MEM_WORDS) begin
                            o.res = shadow_mem[addr];
                            if (r.src_b != 5'd0) shadow_regs[r.src_b] = o.res;
                        end else begin
                            o.err = exu_pkg::ERR_ADDR;
                        end
                    end
                    exu_pkg::OP_SW: begin
                        if (addr < MEM_WORDS) shadow_mem[addr] = b;
                        else o.err = exu_pkg::ERR_ADDR;
                    end
                    exu_pkg::OP_BEQ, exu_pkg::OP_BNE: begin
                        if ((r.opcode == exu_pkg::OP_BEQ) == (a == b)) begin
                            o.tk  = 1'b1;
                            o.npc = r.pc + (simm << 2) - exu_pkg::PC_STEP;
                        end
                    end
                    exu_pkg::OP_J: begin
                        o.tk  = 1'b1;
                        o.npc = ((r.pc + exu_pkg::PC_STEP) & exu_pkg::PC_REGION_MASK)
                              | {4'd0, r.imm, 2'b00};
                    end
                    default: o.err = exu_pkg::ERR_OPCODE;
                endcase
                if (o.err != exu_pkg::ERR_NONE) begin
                    o.res = '0;
                    o.npc = r.pc;
                    o.tk  = 1'b0;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic t_exec_req random_item();
        t_exec_req r;
        r.req_type    = 2'($urandom());
        r.opcode      = 6'($urandom());
        r.func_code   = 6'($urandom());
        r.src_a       = 5'($urandom());
        r.src_b       = 5'($urandom());
        r.dst         = 5'($urandom());
        r.imm         = 26'($urandom());
        r.pc          = $urandom();
        r.reg_index   = 5'($urandom());
        r.write_value = $urandom();
        return r;
    endfunction

    // sends one request, opening a new burst after a random gap when due
    task automatic send_item(input t_exec_req r);
        int unsigned      gap;
        exu_pkg::t_result predicted;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push          <= 1'b1;
        i_req_type    <= r.req_type;
        i_opcode      <= r.opcode;
        i_func_code   <= r.func_code;
        i_src_reg_a   <= r.src_a;
        i_src_reg_b   <= r.src_b;
        i_dest_reg    <= r.dst;
        i_imm_value   <= r.imm;
        i_pc_value    <= r.pc;
        i_reg_index   <= r.reg_index;
        i_write_value <= r.write_value;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predicted       = execute_shadow(r);
        pending_results = {pending_results, predicted};
    endtask

    task automatic send_preload(input logic [4:0] idx, input logic [31:0] value);
        t_exec_req r;
        r             = random_item();
        r.req_type    = exu_pkg::REQ_PRELOAD;
        r.reg_index   = idx;
        r.write_value = value;
        send_item(r);
    endtask

    task automatic send_read(input logic [4:0] idx);
        t_exec_req r;
        r           = random_item();
        r.req_type  = exu_pkg::REQ_READ;
        r.reg_index = idx;
        send_item(r);
    endtask

    task automatic send_exec(input logic [5:0] op, input logic [5:0] fn,
                             input logic [4:0] ra, input logic [4:0] rb,
                             input logic [4:0] rd, input logic [25:0] imm,
                             input logic [31:0] pc);
        t_exec_req r;
        r           = random_item();
        r.req_type  = exu_pkg::REQ_EXEC;
        r.opcode    = op;
        r.func_code = fn;
        r.src_a     = ra;
        r.src_b     = rb;
        r.dst       = rd;
        r.imm       = imm;
        r.pc        = pc;
        send_item(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no result pending");
                error_count++;
            end else begin
                exu_pkg::t_result want;
                want = pending_results.pop_front();
                check_field("result_value", want.res, o_result_value);
                check_field("next_pc", want.npc, o_next_pc);
                check_field("taken", 32'(want.tk), 32'(o_taken));
                check_field("error_code", 32'(want.err), 32'(o_error_code));
            end
        end
    end

    // receiver stall pattern, switching to a random mode whenever its counter runs out
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = t_pop_mode'($urandom_range(0, 3));
                stall_left = $urandom_range(8, 60);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                POP_ALWAYS:  pop <= 1'b1;
                POP_RANDOM:  pop <= 1'($urandom_range(0, 1));
                POP_SPARSE:  pop <= ($urandom_range(0, 3) == 0);
                default:     pop <= (stall_left % 16 == 0);
            endcase
        end
    end

    task automatic test_register_access();
        t_exec_req r;
        send_preload(5'd1, 32'hFFFF_FFFF);
        send_preload(5'd2, 32'h8000_0000);
        send_preload(5'd3, 32'h7FFF_FFFF);
        send_preload(5'd31, 32'd1);
        send_preload(5'd0, 32'hDEAD_BEEF);   // dropped, r0 stays zero
        send_read(5'd0);
        send_read(5'd31);
        r          = random_item();
        r.req_type = REQ_UNUSED;
        send_item(r);
    endtask

    task automatic test_alu_ops();
        send_exec(exu_pkg::OP_RTYPE, exu_pkg::FN_ADD, 5'd1, 5'd31, 5'd4, 26'd0,
                  32'h0000_0100);
        send_exec(exu_pkg::OP_RTYPE, exu_pkg::FN_SUB, 5'd2, 5'd31, 5'd5, 26'd0,
                  32'h0000_0104);
        send_exec(exu_pkg::OP_RTYPE, exu_pkg::FN_AND, 5'd1, 5'd2, 5'd6, 26'd0,
                  32'h0000_0108);
        send_exec(exu_pkg::OP_RTYPE, exu_pkg::FN_OR, 5'd3, 5'd2, 5'd7, 26'd0,
                  32'h0000_010C);
        send_exec(exu_pkg::OP_RTYPE, exu_pkg::FN_SLT, 5'd2, 5'd3, 5'd8, 26'd0,
                  32'h0000_0110);
        send_exec(exu_pkg::OP_RTYPE, exu_pkg::FN_SLT, 5'd3, 5'd2, 5'd0, 26'd0,
                  32'h0000_0114);
        send_exec(exu_pkg::OP_RTYPE, FN_BAD, 5'd1, 5'd1, 5'd9, 26'd0, 32'h0000_0118);
    endtask

    task automatic test_immediate_ops();
        // upper immediate bits must not leak into the sign extension
        send_exec(exu_pkg::OP_ADDI, 6'd0, 5'd0, 5'd10, 5'd0, 26'h3FF_FFFF, 32'h0000_0200);
        send_exec(exu_pkg::OP_ADDI, 6'd0, 5'd1, 5'd0, 5'd0, 26'h000_7FFF, 32'h0000_0204);
    endtask

    task automatic test_memory_ops();
        send_exec(exu_pkg::OP_SW, 6'd0, 5'd0, 5'd1, 5'd0, 26'(MEM_WORDS - 1),
                  32'h0000_0300);
        send_exec(exu_pkg::OP_LW, 6'd0, 5'd0, 5'd11, 5'd0, 26'(MEM_WORDS - 1),
                  32'h0000_0304);
        send_exec(exu_pkg::OP_SW, 6'd0, 5'd0, 5'd2, 5'd0, 26'h3FF_0000, 32'h0000_0308);
        send_exec(exu_pkg::OP_LW, 6'd0, 5'd0, 5'd0, 5'd0, 26'd0, 32'h0000_030C);
        send_exec(exu_pkg::OP_LW, 6'd0, 5'd0, 5'd12, 5'd0, 26'(MEM_WORDS),
                  32'h0000_0310);
        // negative offset wraps to a huge address
        send_exec(exu_pkg::OP_SW, 6'd0, 5'd0, 5'd1, 5'd0, 26'h000_FFFF, 32'h0000_0314);
    endtask

    task automatic test_branches();
        send_exec(exu_pkg::OP_BEQ, 6'd0, 5'd1, 5'd1, 5'd0, 26'h000_8000, 32'h0000_0000);
        send_exec(exu_pkg::OP_BNE, 6'd0, 5'd1, 5'd1, 5'd0, 26'h000_0010, 32'h0000_0404);
        send_exec(exu_pkg::OP_BNE, 6'd0, 5'd1, 5'd2, 5'd0, 26'h000_7FFF, 32'hFFFF_FFF0);
        send_exec(exu_pkg::OP_J, 6'd0, 5'd0, 5'd0, 5'd0, 26'h3FF_FFFF, 32'hEFFF_FFFC);
    endtask

    task automatic test_bad_opcode();
        send_exec(OP_BAD, exu_pkg::FN_ADD, 5'd1, 5'd2, 5'd13, 26'd0, 32'h0000_0500);
    endtask

    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(0, 7));
    endfunction

    // mostly well-formed instructions on a few hot registers, plus noise
    function automatic t_exec_req random_program_item();
        t_exec_req   r;
        int unsigned pick;
        logic [31:0] target;
        r    = random_item();
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            r.req_type  = exu_pkg::REQ_PRELOAD;
            r.reg_index = pick_reg();
            case ($urandom_range(0, 7))
                0:       r.write_value = 32'h0000_0000;
                1:       r.write_value = 32'hFFFF_FFFF;
                2:       r.write_value = 32'h8000_0000;
                3:       r.write_value = 32'h7FFF_FFFF;
                4, 5:    r.write_value = $urandom_range(0, 2 * MEM_WORDS);
                default: ;
            endcase
        end else if (pick < 13) begin
            r.req_type  = exu_pkg::REQ_READ;
            r.reg_index = pick_reg();
        end else if (pick < 15) begin
            r.req_type = REQ_UNUSED;
        end else if (pick < 25) begin
            r.req_type = exu_pkg::REQ_EXEC;
        end else begin
            r.req_type = exu_pkg::REQ_EXEC;
            r.src_a    = pick_reg();
            r.src_b    = pick_reg();
            r.dst      = pick_reg();
            case ($urandom_range(0, 10))
                0: begin
                    r.opcode = exu_pkg::OP_RTYPE; r.func_code = exu_pkg::FN_ADD;
                end
                1: begin
                    r.opcode = exu_pkg::OP_RTYPE; r.func_code = exu_pkg::FN_SUB;
                end
                2: begin
                    r.opcode = exu_pkg::OP_RTYPE; r.func_code = exu_pkg::FN_AND;
                end
                3: begin
                    r.opcode = exu_pkg::OP_RTYPE; r.func_code = exu_pkg::FN_OR;
                end
                4: begin
                    r.opcode = exu_pkg::OP_RTYPE; r.func_code = exu_pkg::FN_SLT;
                end
                5:       r.opcode = exu_pkg::OP_ADDI;
                6:       r.opcode = exu_pkg::OP_LW;
                7:       r.opcode = exu_pkg::OP_SW;
                8:       r.opcode = exu_pkg::OP_BEQ;
                9:       r.opcode = exu_pkg::OP_BNE;
                default: r.opcode = exu_pkg::OP_J;
            endcase
            if (r.opcode == exu_pkg::OP_LW || r.opcode == exu_pkg::OP_SW) begin
                target = ($urandom_range(0, 4) == 0) ?
                         $urandom_range(MEM_WORDS - 4, MEM_WORDS + 3) : $urandom_range(0, 31);
                r.imm[15:0] = 16'(target - shadow_regs[r.src_a]);
            end
            if ((r.opcode == exu_pkg::OP_BEQ || r.opcode == exu_pkg::OP_BNE)
                && $urandom_range(0, 1) == 0)
                r.src_b = r.src_a;
        end
        return r;
    endfunction

    task automatic test_random_program();
        repeat (RANDOM_ITEMS) send_item(random_program_item());
    endtask

    initial begin
        foreach (shadow_regs[i]) shadow_regs[i] = '0;
        foreach (shadow_mem[i]) shadow_mem[i] = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_access();
        test_alu_ops();
        test_immediate_ops();
        test_memory_ops();
        test_branches();
        test_bad_opcode();
        test_random_program();

        @(negedge i_clk);
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[mips_subset_execute_unit] OK");
        end else begin
            $display("[mips_subset_execute_unit] ERROR");
        end
        $finish;
    end

endmodule
